// ===== hw/rtl/hdlctx_pkg.sv =====
// package: line codes, command record and crc step for the hdlc transmit framer
`default_nettype none
package hdlctx_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] CRC_SEED  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h8408;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        lead;
    logic [15:0] fcs;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LEAD,
    BK_DATA,
    BK_CRCL,
    BK_CRCH,
    BK_CLOSE
  } back_st_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] din);
    logic [15:0] c;
    c = crc ^ {8'h00, din};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hdlctx_front.sv =====
// front end: input handshake, frame tracking, crc and the lead flag register
`default_nettype none
module hdlctx_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_last_byte,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_lead_flag_enable,
  input  wire logic              q_full,
  output logic                   q_push,
  output hdlctx_pkg::cmd_t       q_cmd
);

  logic        inside_r, inside_nxt;
  logic        lead_en_r, lead_en_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_step;

  assign in_full   = q_full;
  assign cfg_ready = 1'b1;
  assign q_push    = in_push && !q_full;

  always_comb begin
    crc_step      = hdlctx_pkg::crc_byte(crc_r, in_data_byte);
    q_cmd.data    = in_data_byte;
    q_cmd.last    = in_last_byte;
    q_cmd.lead    = !inside_r && lead_en_r;
    q_cmd.fcs     = ~crc_step;
    inside_nxt    = inside_r;
    crc_nxt       = crc_r;
    lead_en_nxt   = lead_en_r;
    if (q_push) begin
      inside_nxt = !in_last_byte;
      crc_nxt    = in_last_byte ? hdlctx_pkg::CRC_SEED : crc_step;
    end
    if (cfg_valid) begin
      lead_en_nxt = cfg_lead_flag_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r  <= 1'b0;
      lead_en_r <= 1'b1;
      crc_r     <= hdlctx_pkg::CRC_SEED;
    end else begin
      inside_r  <= inside_nxt;
      lead_en_r <= lead_en_nxt;
      crc_r     <= crc_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hdlctx_cmdq.sv =====
// command queue between front and back end
`default_nettype none
module hdlctx_cmdq #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire hdlctx_pkg::cmd_t  push_cmd,
  output logic                   full,
  input  wire logic              pop,
  output hdlctx_pkg::cmd_t       pop_cmd,
  output logic                   empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  hdlctx_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hdlctx_back.sv =====
// back end: line byte sequencer with escaping and the result register
`default_nettype none
module hdlctx_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire hdlctx_pkg::cmd_t  q_cmd,
  output logic                   q_pop,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic [7:0]             out_byte,
  output logic                   out_run_last,
  output logic                   out_frame_end
);

  hdlctx_pkg::back_st_t st_r, st_nxt;
  hdlctx_pkg::cmd_t     cmd_r, cmd_nxt;
  logic                 esc_r, esc_nxt;
  logic                 ov_r, ov_nxt;
  logic [7:0]           ob_r, ob_nxt;
  logic                 orl_r, orl_nxt;
  logic                 ofe_r, ofe_nxt;
  logic                 adv, emit, done;
  logic [7:0]           sel;
  logic                 special;

  assign out_empty     = !ov_r;
  assign out_byte      = ob_r;
  assign out_run_last  = orl_r;
  assign out_frame_end = ofe_r;
  assign adv           = !ov_r || out_pop;

  always_comb begin
    st_nxt  = st_r;
    cmd_nxt = cmd_r;
    esc_nxt = esc_r;
    ov_nxt  = ov_r && !out_pop;
    ob_nxt  = ob_r;
    orl_nxt = orl_r;
    ofe_nxt = ofe_r;
    emit    = 1'b0;
    done    = 1'b0;
    q_pop   = 1'b0;
    case (st_r)
      hdlctx_pkg::BK_CRCL: sel = cmd_r.fcs[7:0];
      hdlctx_pkg::BK_CRCH: sel = cmd_r.fcs[15:8];
      default:             sel = cmd_r.data;
    endcase
    special = (sel == hdlctx_pkg::FLAG_BYTE) || (sel == hdlctx_pkg::ESC_BYTE);
    if (adv) begin
      case (st_r)
        hdlctx_pkg::BK_IDLE: begin
        end
        hdlctx_pkg::BK_LEAD: begin
          emit   = 1'b1;
          ob_nxt = hdlctx_pkg::FLAG_BYTE;
          ofe_nxt = 1'b0;
          st_nxt = hdlctx_pkg::BK_DATA;
        end
        hdlctx_pkg::BK_DATA, hdlctx_pkg::BK_CRCL, hdlctx_pkg::BK_CRCH: begin
          emit    = 1'b1;
          ofe_nxt = 1'b0;
          if (special && !esc_r) begin
            ob_nxt  = hdlctx_pkg::ESC_BYTE;
            esc_nxt = 1'b1;
          end else begin
            ob_nxt  = esc_r ? (sel ^ hdlctx_pkg::ESC_XOR) : sel;
            esc_nxt = 1'b0;
            case (st_r)
              hdlctx_pkg::BK_DATA: begin
                if (cmd_r.last) begin
                  st_nxt = hdlctx_pkg::BK_CRCL;
                end else begin
                  done = 1'b1;
                end
              end
              hdlctx_pkg::BK_CRCL: st_nxt = hdlctx_pkg::BK_CRCH;
              default:             st_nxt = hdlctx_pkg::BK_CLOSE;
            endcase
          end
        end
        hdlctx_pkg::BK_CLOSE: begin
          emit    = 1'b1;
          ob_nxt  = hdlctx_pkg::FLAG_BYTE;
          ofe_nxt = 1'b1;
          done    = 1'b1;
        end
        default: st_nxt = hdlctx_pkg::BK_IDLE;
      endcase
    end
    if (emit) begin
      ov_nxt  = 1'b1;
      orl_nxt = done;
    end
    // load the next command when idle or when the current one finishes
    if ((st_r == hdlctx_pkg::BK_IDLE) || done) begin
      if (!q_empty) begin
        q_pop   = 1'b1;
        cmd_nxt = q_cmd;
        esc_nxt = 1'b0;
        st_nxt  = q_cmd.lead ? hdlctx_pkg::BK_LEAD : hdlctx_pkg::BK_DATA;
      end else begin
        st_nxt  = hdlctx_pkg::BK_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= hdlctx_pkg::BK_IDLE;
      esc_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      esc_r <= esc_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    ob_r  <= ob_nxt;
    orl_r <= orl_nxt;
    ofe_r <= ofe_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hdlc_tx_framer_crc16.sv =====
// top level of the hdlc transmit framer with crc-16 x.25 trailer
//
//   channel   handshake             payload
//   in        in_push / in_full     in_data_byte, in_last_byte
//   out       out_pop / out_empty   out_byte, out_run_last, out_frame_end
//   cfg       cfg_valid / cfg_ready cfg_lead_flag_enable
//
// one line byte leaves per cycle unless out_pop stalls; an input byte makes
// 1 to 8 line bytes (lead flag, escapes, crc bytes, closing flag)
// the front end takes a byte every cycle until the command queue fills
// synchronous active-low reset; crc returns to 0xffff, lead flag enabled
// a stalled out_pop holds the result register and backs up into the queue
`default_nettype none
module hdlc_tx_framer_crc16 #(
  parameter int CMDQ_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last_byte,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_frame_end,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_lead_flag_enable
);

  hdlctx_pkg::cmd_t push_cmd, pop_cmd;
  logic             q_push, q_full, q_pop, q_empty;

  hdlctx_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_data_byte         (in_data_byte),
    .in_last_byte         (in_last_byte),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_lead_flag_enable (cfg_lead_flag_enable),
    .q_full               (q_full),
    .q_push               (q_push),
    .q_cmd                (push_cmd)
  );

  hdlctx_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  hdlctx_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_cmd         (pop_cmd),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

endmodule
`default_nettype wire
